/* rtl/hack_instruction_line_encoder_defines.svh */
// assertion macros for the hack instruction line encoder
// included by rtl modules that carry concurrent checks
`ifndef HACK_INSTRUCTION_LINE_ENCODER_DEFINES_SVH
`define HACK_INSTRUCTION_LINE_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define HILE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
`define HILE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define HILE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HILE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/hile_pkg.sv */
// shared types, constants and mnemonic tables for the line encoder
// no dependencies
package hile_pkg;

    localparam int HILE_MAX_LINE = 16;
    localparam int ADDR_BITS     = 15;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_COMP     = 3'd1;
    localparam logic [2:0] ERR_DEST     = 3'd2;
    localparam logic [2:0] ERR_JUMP     = 3'd3;
    localparam logic [2:0] ERR_DIGIT    = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

    typedef logic [3:0][7:0] buf4_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic eval;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic sweep_done;
    } stat_t;

    // returns {valid, code}
    function automatic logic [7:0] comp_lookup(input buf4_t s, input logic [2:0] len);
        logic [7:0] r;
        r = 8'd0;
        unique case (len)
            3'd1: begin
                unique case (s[0])
                    "0":     r = {1'b1, 7'h2A};
                    "1":     r = {1'b1, 7'h3F};
                    "D":     r = {1'b1, 7'h0C};
                    "A":     r = {1'b1, 7'h30};
                    "M":     r = {1'b1, 7'h70};
                    default: r = 8'd0;
                endcase
            end
            3'd2: begin
                unique case ({s[0], s[1]})
                    "-1":    r = {1'b1, 7'h3A};
                    "!D":    r = {1'b1, 7'h0D};
                    "!A":    r = {1'b1, 7'h31};
                    "-D":    r = {1'b1, 7'h0F};
                    "-A":    r = {1'b1, 7'h33};
                    "!M":    r = {1'b1, 7'h71};
                    "-M":    r = {1'b1, 7'h73};
                    default: r = 8'd0;
                endcase
            end
            3'd3: begin
                unique case ({s[0], s[1], s[2]})
                    "D+1":   r = {1'b1, 7'h1F};
                    "A+1":   r = {1'b1, 7'h37};
                    "D-1":   r = {1'b1, 7'h0E};
                    "A-1":   r = {1'b1, 7'h32};
                    "D+A":   r = {1'b1, 7'h02};
                    "D-A":   r = {1'b1, 7'h13};
                    "A-D":   r = {1'b1, 7'h07};
                    "D&A":   r = {1'b1, 7'h00};
                    "D|A":   r = {1'b1, 7'h15};
                    "M+1":   r = {1'b1, 7'h77};
                    "M-1":   r = {1'b1, 7'h72};
                    "D+M":   r = {1'b1, 7'h42};
                    "D-M":   r = {1'b1, 7'h53};
                    "M-D":   r = {1'b1, 7'h47};
                    "D&M":   r = {1'b1, 7'h40};
                    "D|M":   r = {1'b1, 7'h55};
                    default: r = 8'd0;
                endcase
            end
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] dest_lookup(input buf4_t s, input logic [2:0] len);
        logic [3:0] r;
        r = 4'd0;
        unique case (len)
            3'd1: begin
                unique case (s[0])
                    "M":     r = 4'b1001;
                    "D":     r = 4'b1010;
                    "A":     r = 4'b1100;
                    default: r = 4'd0;
                endcase
            end
            3'd2: begin
                unique case ({s[0], s[1]})
                    "MD":    r = 4'b1011;
                    "AM":    r = 4'b1101;
                    "AD":    r = 4'b1110;
                    default: r = 4'd0;
                endcase
            end
            3'd3:    r = ({s[0], s[1], s[2]} == "AMD") ? 4'b1111 : 4'd0;
            3'd4:    r = ({s[0], s[1], s[2], s[3]} == "null") ? 4'b1000 : 4'd0;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] jump_lookup(input buf4_t s, input logic [2:0] len);
        logic [3:0] r;
        r = 4'd0;
        unique case (len)
            3'd3: begin
                unique case ({s[0], s[1], s[2]})
                    "JGT":   r = 4'b1001;
                    "JEQ":   r = 4'b1010;
                    "JGE":   r = 4'b1011;
                    "JLT":   r = 4'b1100;
                    "JNE":   r = 4'b1101;
                    "JLE":   r = 4'b1110;
                    "JMP":   r = 4'b1111;
                    default: r = 4'd0;
                endcase
            end
            3'd4:    r = ({s[0], s[1], s[2], s[3]} == "null") ? 4'b1000 : 4'd0;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/hack_instruction_line_encoder.sv */
// hack instruction line encoder: one character per item, one 16-bit word per line
// characters are taken one per cycle while idle; after the last one the buffer is swept
// through its single ram read port, each swept character being read and then evaluated,
// and the result is loaded once any previous result has been taken at the output
// synchronous active-low reset clears control state; buffer contents are not cleared
// depends on hile_pkg, hile_ctrl, hile_dp, hile_ram
module hack_instruction_line_encoder #(
    parameter int MAX_LINE = hile_pkg::HILE_MAX_LINE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // character[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // machine_word[15:0], error_code[18:16], zero pad
);
    import hile_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [15:0] word;
    logic [2:0]  err;

    hile_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    hile_dp #(.MAX_LINE(MAX_LINE)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .character    (s_tdata),
        .machine_word (word),
        .error_code   (err)
    );

    assign m_tdata = {5'd0, err, word};
endmodule

/* rtl/hile_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module hile_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/hile_dp.sv */
// datapath: line buffer, split and digit scan, mnemonic lookup, result register
// depends on hile_pkg and hile_ram
module hile_dp #(
    parameter int MAX_LINE = hile_pkg::HILE_MAX_LINE
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  hile_pkg::cmd_t  cmd,
    output hile_pkg::stat_t stat,
    input  logic [7:0]    character,
    output logic [15:0]   machine_word,
    output logic [2:0]    error_code
);
    import hile_pkg::*;

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int AW = $clog2(MAX_LINE);
    localparam logic [CW-1:0] MAXC = CW'(MAX_LINE);
    localparam logic [CW-1:0] FOUR = CW'(4);
    localparam logic [18:0]   ADDR_MAX = 19'((1 << ADDR_BITS) - 1);

    logic [CW-1:0] cnt_reg, cnt_next, eq_idx_reg, eq_idx_next;
    logic [CW-1:0] addr_reg, addr_next, rs_reg, rs_next, semi_reg, semi_next;
    logic          over_reg, over_next, eq_reg, eq_next, at_reg, at_next;
    logic          semi_f_reg, semi_f_next, bad_reg, bad_next, ovf_reg, ovf_next;
    logic [14:0]   val_reg, val_next;
    buf4_t         dbuf_reg, dbuf_next, cbuf_reg, cbuf_next, jbuf_reg, jbuf_next;
    logic [15:0]   word_reg, word_next;
    logic [2:0]    err_reg, err_next;

    logic          ram_we;
    logic [7:0]    rdata;
    logic [CW-1:0] crel, jrel, cl, jl;
    logic [2:0]    cl3, dl3, jl3;
    logic [18:0]   acc;
    logic [3:0]    digit;
    logic          is_digit, dest_given, jump_given;
    logic [7:0]    cres;
    logic [3:0]    dres, jres;
    logic [15:0]   res_word;
    logic [2:0]    res_err;

    assign ram_we = cmd.accept && (cnt_reg < MAXC);

    hile_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (character),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign stat.sweep_done = (addr_reg >= cnt_reg);

    assign is_digit = (rdata >= "0") && (rdata <= "9");
    assign digit    = 4'(rdata - "0");
    assign acc      = {1'b0, val_reg, 3'b000} + {3'b000, val_reg, 1'b0} + {15'd0, digit};
    assign crel     = addr_reg - rs_reg;
    assign jrel     = addr_reg - semi_reg - CW'(1);

    always_comb begin
        cnt_next    = cnt_reg;
        over_next   = over_reg;
        eq_next     = eq_reg;
        eq_idx_next = eq_idx_reg;
        at_next     = at_reg;
        dbuf_next   = dbuf_reg;
        addr_next   = addr_reg;
        rs_next     = rs_reg;
        semi_f_next = semi_f_reg;
        semi_next   = semi_reg;
        bad_next    = bad_reg;
        ovf_next    = ovf_reg;
        val_next    = val_reg;
        cbuf_next   = cbuf_reg;
        jbuf_next   = jbuf_reg;
        word_next   = word_reg;
        err_next    = err_reg;
        if (cmd.accept) begin
            if (cnt_reg < MAXC) begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == '0) begin
                    at_next = (character == "@");
                end
                if (!eq_reg && character == "=") begin
                    eq_next     = 1'b1;
                    eq_idx_next = cnt_reg;
                end
                if (cnt_reg < FOUR) begin
                    dbuf_next[cnt_reg[1:0]] = character;
                end
            end else begin
                over_next = 1'b1;
            end
        end
        if (cmd.init) begin
            semi_f_next = 1'b0;
            bad_next    = 1'b0;
            ovf_next    = 1'b0;
            val_next    = '0;
            if (at_reg) begin
                rs_next = CW'(1);
            end else if (eq_reg && eq_idx_reg != '0) begin
                rs_next = eq_idx_reg + CW'(1);
            end else begin
                rs_next = '0;
            end
            addr_next = rs_next;
        end
        if (cmd.eval) begin
            addr_next = addr_reg + CW'(1);
            if (!is_digit) begin
                bad_next = 1'b1;
            end else if (acc > ADDR_MAX) begin
                ovf_next = 1'b1;
            end else begin
                val_next = acc[14:0];
            end
            if (crel < FOUR) begin
                cbuf_next[crel[1:0]] = rdata;
            end
            if (semi_f_reg && jrel < FOUR) begin
                jbuf_next[jrel[1:0]] = rdata;
            end
            if (!semi_f_reg && rdata == ";") begin
                semi_f_next = 1'b1;
                semi_next   = addr_reg;
            end
        end
        if (cmd.load) begin
            word_next = res_word;
            err_next  = res_err;
            cnt_next  = '0;
            over_next = 1'b0;
            eq_next   = 1'b0;
        end
    end

    always_comb begin
        jump_given = semi_f_reg && (semi_reg != rs_reg);
        dest_given = eq_reg && (eq_idx_reg != '0);
        cl = jump_given ? (semi_reg - rs_reg) : (cnt_reg - rs_reg);
        jl = cnt_reg - semi_reg - CW'(1);
        cl3 = (cl > FOUR) ? 3'd7 : cl[2:0];
        jl3 = (jl > FOUR) ? 3'd7 : jl[2:0];
        dl3 = (eq_idx_reg > FOUR) ? 3'd7 : eq_idx_reg[2:0];
        cres = comp_lookup(cbuf_reg, cl3);
        dres = dest_given ? dest_lookup(dbuf_reg, dl3) : 4'b1000;
        jres = jump_given ? jump_lookup(jbuf_reg, jl3) : 4'b1000;
        res_word = '0;
        res_err  = ERR_OK;
        if (at_reg) begin
            if (cnt_reg < CW'(2) || bad_reg) begin
                res_err = ERR_DIGIT;
            end else if (over_reg || ovf_reg) begin
                res_err = ERR_OVERFLOW;
            end else begin
                res_word = {1'b0, val_reg};
            end
        end else if (over_reg || !cres[7]) begin
            res_err = ERR_COMP;
        end else if (!dres[3]) begin
            res_err = ERR_DEST;
        end else if (!jres[3]) begin
            res_err = ERR_JUMP;
        end else begin
            res_word = {3'b111, cres[6:0], dres[2:0], jres[2:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            over_reg   <= 1'b0;
            eq_reg     <= 1'b0;
            semi_f_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            over_reg   <= over_next;
            eq_reg     <= eq_next;
            semi_f_reg <= semi_f_next;
        end
        eq_idx_reg <= eq_idx_next;
        at_reg     <= at_next;
        dbuf_reg   <= dbuf_next;
        addr_reg   <= addr_next;
        rs_reg     <= rs_next;
        semi_reg   <= semi_next;
        bad_reg    <= bad_next;
        ovf_reg    <= ovf_next;
        val_reg    <= val_next;
        cbuf_reg   <= cbuf_next;
        jbuf_reg   <= jbuf_next;
        word_reg   <= word_next;
        err_reg    <= err_next;
    end

    assign machine_word = word_reg;
    assign error_code   = err_reg;
endmodule

/* rtl/hile_ctrl.sv */
// controller: accepts characters, sequences the buffer sweep, owns result valid
// depends on hile_pkg and the assertion macro header
`include "hack_instruction_line_encoder_defines.svh"
module hile_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    output hile_pkg::cmd_t  cmd,
    input  hile_pkg::stat_t stat
);
    import hile_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       acc;

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = acc;
        unique case (state_reg)
            S_IDLE: if (acc && s_tlast) begin
                state_next = S_INIT;
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = stat.sweep_done ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_READ;
            end
            S_DONE: if (!valid_reg || m_tready) begin
                cmd.load   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        valid_next = cmd.load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    `HILE_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.load, !valid_reg || m_tready)
    `HILE_ASSERT_NXT(a_last_init, aclk, aresetn, acc && s_tlast, state_reg == S_INIT)
    `HILE_ASSERT_IMP(a_rise_done, aclk, aresetn, $rose(valid_reg), $past(state_reg) == S_DONE)
    `HILE_ASSERT_NXT(a_eval_read, aclk, aresetn, cmd.eval, state_reg == S_READ)
endmodule
